// ----- rtl/box_match_score_macros.svh -----
// ----------------------------------------------------------------------------
// box_match_score assertion macros
// Shared concurrent property wrappers on clk with arst_n disable.
// ----------------------------------------------------------------------------
`ifndef BOX_MATCH_SCORE_MACROS_SVH
`define BOX_MATCH_SCORE_MACROS_SVH

// same-cycle implication
`define BMS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bms_pkg.sv -----
// ----------------------------------------------------------------------------
// bms_pkg
// Shared constants and types of the box match score block.
// ----------------------------------------------------------------------------
package bms_pkg;

	localparam int COORD_BITS_DEF = 14;
	localparam int FRAC_BITS_DEF  = 15;
	localparam int QUEUE_DEPTH    = 4;
	localparam int IMG_W_RST      = 1920;
	localparam int IMG_H_RST      = 1080;

	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

// ----- rtl/bms_front.sv -----
// ----------------------------------------------------------------------------
// bms_front
// Takes box pairs, works out overlap extents and centre offsets, and queues
// the words for the back end.
// ----------------------------------------------------------------------------
module bms_front #(
	parameter int COORD_BITS = bms_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] det_x,
	input  logic signed [COORD_BITS-1:0] det_y,
	input  logic        [COORD_BITS-2:0] det_w,
	input  logic        [COORD_BITS-2:0] det_h,
	input  logic signed [COORD_BITS-1:0] trk_x,
	input  logic signed [COORD_BITS-1:0] trk_y,
	input  logic        [COORD_BITS-2:0] trk_w,
	input  logic        [COORD_BITS-2:0] trk_h,
	input  logic                         pop,
	output bms_pkg::q_stat_t             q_stat,
	output logic        [COORD_BITS-2:0] hd_ix,
	output logic        [COORD_BITS-2:0] hd_iy,
	output logic signed [COORD_BITS+2:0] hd_dx,
	output logic signed [COORD_BITS+2:0] hd_dy,
	output logic        [COORD_BITS-2:0] hd_aw,
	output logic        [COORD_BITS-2:0] hd_ah,
	output logic        [COORD_BITS-2:0] hd_bw,
	output logic        [COORD_BITS-2:0] hd_bh
);

	localparam int CB    = COORD_BITS;
	localparam int SZ    = CB - 1;
	localparam int DW    = CB + 3;
	localparam int EW    = 6 * SZ + 2 * DW;
	localparam int DEPTH = bms_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [SZ-1:0] overlap(
		input logic signed [CB:0] a0,
		input logic signed [CB:0] a1,
		input logic signed [CB:0] b0,
		input logic signed [CB:0] b1
	);
		logic signed [CB:0]   lo;
		logic signed [CB:0]   hi;
		logic signed [CB+1:0] ext;
		begin
			lo  = (a0 > b0) ? a0 : b0;
			hi  = (a1 < b1) ? a1 : b1;
			ext = (CB+2)'(hi) - (CB+2)'(lo);
			overlap = (ext > 0) ? ext[SZ-1:0] : '0;
		end
	endfunction

	logic signed [CB:0]   ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
	logic signed [CB+1:0] cax, cbx, cay, cby;
	logic signed [DW-1:0] dx, dy;
	logic [SZ-1:0]        ix, iy;
	logic [EW-1:0]        wr_word, rd_word;
	logic [EW-1:0]        mem_q [DEPTH];
	logic [AW-1:0]        wr_ptr_q, rd_ptr_q;
	logic [AW:0]          cnt_q;
	logic                 push;

	assign ax0 = (CB+1)'(det_x);
	assign ax1 = ax0 + $signed((CB+1)'(det_w));
	assign bx0 = (CB+1)'(trk_x);
	assign bx1 = bx0 + $signed((CB+1)'(trk_w));
	assign ay0 = (CB+1)'(det_y);
	assign ay1 = ay0 + $signed((CB+1)'(det_h));
	assign by0 = (CB+1)'(trk_y);
	assign by1 = by0 + $signed((CB+1)'(trk_h));

	assign ix = overlap(ax0, ax1, bx0, bx1);
	assign iy = overlap(ay0, ay1, by0, by1);

	// centres in half pixels
	assign cax = ((CB+2)'(det_x) <<< 1) + $signed((CB+2)'(det_w));
	assign cbx = ((CB+2)'(trk_x) <<< 1) + $signed((CB+2)'(trk_w));
	assign cay = ((CB+2)'(det_y) <<< 1) + $signed((CB+2)'(det_h));
	assign cby = ((CB+2)'(trk_y) <<< 1) + $signed((CB+2)'(trk_h));
	assign dx  = DW'(cax) - DW'(cbx);
	assign dy  = DW'(cay) - DW'(cby);

	assign wr_word = {ix, iy, dx, dy, det_w, det_h, trk_w, trk_h};

	assign q_stat.full  = (cnt_q == (AW+1)'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign in_stall     = q_stat.full;
	assign push         = in_valid && !q_stat.full;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign rd_word = mem_q[rd_ptr_q];
	assign {hd_ix, hd_iy, hd_dx, hd_dy, hd_aw, hd_ah, hd_bw, hd_bh} = rd_word;

endmodule

// ----- rtl/bms_sqrt.sv -----
// ----------------------------------------------------------------------------
// bms_sqrt
// Two-lane pipelined integer square root, one root bit per stage, with a
// payload carried alongside.
// ----------------------------------------------------------------------------
module bms_sqrt #(
	parameter int R     = 17,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             en,
	input  logic [2*R-1:0]   rad_a,
	input  logic [2*R-1:0]   rad_b,
	input  logic [TAG_W-1:0] tag_i,
	output logic [R-1:0]     root_a,
	output logic [R-1:0]     root_b,
	output logic [TAG_W-1:0] tag_o
);

	logic [R:0]       rem_q  [R][2];
	logic [R-1:0]     root_q [R][2];
	logic [2*R-1:0]   rad_q  [R][2];
	logic [TAG_W-1:0] tag_q  [R];
	logic [2*R-1:0]   rad_in [2];

	assign rad_in[0] = rad_a;
	assign rad_in[1] = rad_b;

	for (genvar k = 0; k < R; k++) begin : g_stage
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [R:0]     rem_i;
			logic [R-1:0]   root_i;
			logic [2*R-1:0] rad_i;
			logic [R+2:0]   t;
			logic [R+2:0]   trial;
			logic           ge;

			if (k == 0) begin : g_first
				assign rem_i  = '0;
				assign root_i = '0;
				assign rad_i  = rad_in[l];
			end else begin : g_next
				assign rem_i  = rem_q[k-1][l];
				assign root_i = root_q[k-1][l];
				assign rad_i  = rad_q[k-1][l];
			end

			assign t     = {rem_i, rad_i[2*R-1 -: 2]};
			assign trial = {1'b0, root_i, 2'b01};
			assign ge    = (t >= trial);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k][l]  <= ge ? (R+1)'(t - trial) : t[R:0];
					root_q[k][l] <= {root_i[R-2:0], ge};
					rad_q[k][l]  <= rad_i << 2;
				end
			end
		end

		if (k == 0) begin : g_tag_first
			always_ff @(posedge clk) begin
				if (en) begin
					tag_q[k] <= tag_i;
				end
			end
		end else begin : g_tag_next
			always_ff @(posedge clk) begin
				if (en) begin
					tag_q[k] <= tag_q[k-1];
				end
			end
		end
	end

	assign root_a = root_q[R-1][0];
	assign root_b = root_q[R-1][1];
	assign tag_o  = tag_q[R-1];

endmodule

// ----- rtl/bms_div.sv -----
// ----------------------------------------------------------------------------
// bms_div
// Pipelined restoring divider, one quotient bit per stage, with a payload
// carried alongside. The dividend's upper part must stay below the divisor.
// ----------------------------------------------------------------------------
module bms_div #(
	parameter int DVD_W = 41,
	parameter int DEN_W = 27,
	parameter int Q_W   = 16,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DVD_W-1:0] dvd,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_i,
	output logic [Q_W-1:0]   quo,
	output logic [TAG_W-1:0] tag_o
);

	logic [DEN_W-1:0] rem_q [Q_W];
	logic [Q_W-1:0]   low_q [Q_W];
	logic [Q_W-1:0]   quo_q [Q_W];
	logic [DEN_W-1:0] den_q [Q_W];
	logic [TAG_W-1:0] tag_q [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [DEN_W-1:0] rem_i;
		logic [DEN_W-1:0] den_i;
		logic [Q_W-1:0]   low_i;
		logic [Q_W-1:0]   quo_i;
		logic [TAG_W-1:0] tag_k;
		logic [DEN_W:0]   t;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_i = DEN_W'(dvd[DVD_W-1:Q_W]);
			assign low_i = dvd[Q_W-1:0];
			assign quo_i = '0;
			assign den_i = den;
			assign tag_k = tag_i;
		end else begin : g_next
			assign rem_i = rem_q[k-1];
			assign low_i = low_q[k-1];
			assign quo_i = quo_q[k-1];
			assign den_i = den_q[k-1];
			assign tag_k = tag_q[k-1];
		end

		assign t    = {rem_i, low_i[Q_W-1]};
		assign diff = t - {1'b0, den_i};
		assign ge   = (t >= {1'b0, den_i});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
				low_q[k] <= low_i << 1;
				quo_q[k] <= {quo_i[Q_W-2:0], ge};
				den_q[k] <= den_i;
				tag_q[k] <= tag_k;
			end
		end
	end

	assign quo   = quo_q[Q_W-1];
	assign tag_o = tag_q[Q_W-1];

endmodule

// ----- rtl/bms_back.sv -----
// ----------------------------------------------------------------------------
// bms_back
// Pulls queued words, forms areas and squared distances, takes the roots and
// quotients, and blends the three terms into the score.
// ----------------------------------------------------------------------------
module bms_back #(
	parameter int COORD_BITS = bms_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = bms_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bms_pkg::q_stat_t             q_stat,
	output logic                         pop,
	input  logic        [COORD_BITS-2:0] hd_ix,
	input  logic        [COORD_BITS-2:0] hd_iy,
	input  logic signed [COORD_BITS+2:0] hd_dx,
	input  logic signed [COORD_BITS+2:0] hd_dy,
	input  logic        [COORD_BITS-2:0] hd_aw,
	input  logic        [COORD_BITS-2:0] hd_ah,
	input  logic        [COORD_BITS-2:0] hd_bw,
	input  logic        [COORD_BITS-2:0] hd_bh,
	input  logic        [COORD_BITS-2:0] image_width,
	input  logic        [COORD_BITS-2:0] image_height,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic        [FRAC_BITS:0]    score
);

	localparam int SZ     = COORD_BITS - 1;
	localparam int DW     = COORD_BITS + 3;
	localparam int A      = 2 * SZ;
	localparam int UW     = A + 1;
	localparam int R      = COORD_BITS + 3;
	localparam int SQW    = 2 * R;
	localparam int Q      = FRAC_BITS + 1;
	localparam int TW     = 3 * A + UW + 2;
	localparam int NST    = R + Q + 3;
	localparam int AC     = 2 * FRAC_BITS + 2;
	localparam int ONE    = 1 << FRAC_BITS;
	localparam int W_IOU  = ONE / 2;
	localparam int W_DIST = (3 * ONE) / 10;
	localparam int W_SIZE = ONE - W_IOU - W_DIST;

	logic                   en;
	logic [NST-1:0]         vld_q;
	logic signed [2*DW-1:0] dx_sq, dy_sq;

	logic [A-1:0]     inter_s1, area_a_s1, area_b_s1, iw2_s1, ih2_s1;
	logic [2*R-3:0]   dx2_s1, dy2_s1;
	logic [A-1:0]     inter_s2, lo_s2, hi_s2;
	logic [UW-1:0]    union_s2;
	logic [SQW-1:0]   sum_s2, diag_s2;
	logic             uz_s2, sz_s2;

	logic [R-1:0]     rt_d, rt_g;
	logic [TW-1:0]    sq_tag;
	logic [A-1:0]     t_inter, t_lo, t_hi;
	logic [UW-1:0]    t_union;
	logic             t_uz, t_sz;
	logic [R:0]       gh;
	logic             clamp;

	logic [Q-1:0]     q_iou, q_size, q_ratio;
	logic             d_uz, d_sz, d_clamp;
	logic [Q-1:0]     iou_v, size_v, ratio_v, ndist_v;
	logic [AC-1:0]    acc;
	logic [FRAC_BITS:0] score_q;

	assign en  = !(vld_q[NST-1] && out_stall);
	assign pop = en && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], !q_stat.empty};
		end
	end

	assign dx_sq = hd_dx * hd_dx;
	assign dy_sq = hd_dy * hd_dy;

	always_ff @(posedge clk) begin
		if (en) begin
			inter_s1  <= A'(hd_ix) * A'(hd_iy);
			area_a_s1 <= A'(hd_aw) * A'(hd_ah);
			area_b_s1 <= A'(hd_bw) * A'(hd_bh);
			dx2_s1    <= dx_sq[2*R-3:0];
			dy2_s1    <= dy_sq[2*R-3:0];
			iw2_s1    <= A'(image_width) * A'(image_width);
			ih2_s1    <= A'(image_height) * A'(image_height);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inter_s2 <= inter_s1;
			union_s2 <= UW'(area_a_s1) + UW'(area_b_s1) - UW'(inter_s1);
			lo_s2    <= (area_a_s1 < area_b_s1) ? area_a_s1 : area_b_s1;
			hi_s2    <= (area_a_s1 < area_b_s1) ? area_b_s1 : area_a_s1;
			uz_s2    <= (area_a_s1 == '0) && (area_b_s1 == '0);
			sz_s2    <= (area_a_s1 == '0) || (area_b_s1 == '0);
			sum_s2   <= SQW'(dx2_s1) + SQW'(dy2_s1);
			diag_s2  <= SQW'(iw2_s1) + SQW'(ih2_s1);
		end
	end

	bms_sqrt #(
		.R     (R),
		.TAG_W (TW)
	) u_sqrt (
		.clk    (clk),
		.en     (en),
		.rad_a  (sum_s2),
		.rad_b  (diag_s2),
		.tag_i  ({inter_s2, union_s2, lo_s2, hi_s2, uz_s2, sz_s2}),
		.root_a (rt_d),
		.root_b (rt_g),
		.tag_o  (sq_tag)
	);

	assign {t_inter, t_union, t_lo, t_hi, t_uz, t_sz} = sq_tag;

	// diagonal in half pixels; far or degenerate cases saturate the ratio
	assign gh    = {rt_g, 1'b0};
	assign clamp = (gh == '0) || ({1'b0, rt_d} >= gh);

	bms_div #(
		.DVD_W (A + FRAC_BITS),
		.DEN_W (UW),
		.Q_W   (Q),
		.TAG_W (1)
	) u_div_iou (
		.clk   (clk),
		.en    (en),
		.dvd   ({t_inter, {FRAC_BITS{1'b0}}}),
		.den   (t_union),
		.tag_i (t_uz),
		.quo   (q_iou),
		.tag_o (d_uz)
	);

	bms_div #(
		.DVD_W (A + FRAC_BITS),
		.DEN_W (A),
		.Q_W   (Q),
		.TAG_W (1)
	) u_div_size (
		.clk   (clk),
		.en    (en),
		.dvd   ({t_lo, {FRAC_BITS{1'b0}}}),
		.den   (t_hi),
		.tag_i (t_sz),
		.quo   (q_size),
		.tag_o (d_sz)
	);

	bms_div #(
		.DVD_W (R + FRAC_BITS),
		.DEN_W (R + 1),
		.Q_W   (Q),
		.TAG_W (1)
	) u_div_ratio (
		.clk   (clk),
		.en    (en),
		.dvd   ({rt_d, {FRAC_BITS{1'b0}}}),
		.den   (gh),
		.tag_i (clamp),
		.quo   (q_ratio),
		.tag_o (d_clamp)
	);

	assign iou_v   = d_uz ? '0 : q_iou;
	assign size_v  = d_sz ? '0 : q_size;
	assign ratio_v = d_clamp ? Q'(ONE) : q_ratio;
	assign ndist_v = Q'(ONE) - ratio_v;
	assign acc     = AC'(W_IOU) * AC'(iou_v) + AC'(W_DIST) * AC'(ndist_v)
		+ AC'(W_SIZE) * AC'(size_v);

	always_ff @(posedge clk) begin
		if (en) begin
			score_q <= acc[2*FRAC_BITS:FRAC_BITS];
		end
	end

	assign out_valid = vld_q[NST-1];
	assign score     = score_q;

endmodule

// ----- rtl/box_match_score.sv -----
// ----------------------------------------------------------------------------
// box_match_score
// Q1.FRAC_BITS match score of a detection box against a track box.
// ----------------------------------------------------------------------------
// Takes one box pair per clock while in_stall is low and returns one score
// per pair, in order. The pipeline runs through the area and distance stages,
// the square-root stages (one root bit per stage), the dividers (one quotient
// bit per stage) and a score register. A four-word queue sits between the
// input and the pipeline, so input stall rises only when that queue is full.
// Image width and height may be written only while no pair is in flight.
`include "box_match_score_macros.svh"

module box_match_score #(
	parameter int COORD_BITS = bms_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = bms_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr,
	input  logic                         cfg_idx,
	input  logic        [COORD_BITS-2:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] det_x,
	input  logic signed [COORD_BITS-1:0] det_y,
	input  logic        [COORD_BITS-2:0] det_w,
	input  logic        [COORD_BITS-2:0] det_h,
	input  logic signed [COORD_BITS-1:0] trk_x,
	input  logic signed [COORD_BITS-1:0] trk_y,
	input  logic        [COORD_BITS-2:0] trk_w,
	input  logic        [COORD_BITS-2:0] trk_h,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic        [FRAC_BITS:0]    score
);

	localparam int SZ = COORD_BITS - 1;
	localparam logic [FRAC_BITS:0] SCORE_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [SZ-1:0]            img_w_q, img_h_q;
	bms_pkg::q_stat_t         q_stat;
	logic                     pop;
	logic [SZ-1:0]            hd_ix, hd_iy, hd_aw, hd_ah, hd_bw, hd_bh;
	logic signed [COORD_BITS+2:0] hd_dx, hd_dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= SZ'(bms_pkg::IMG_W_RST);
			img_h_q <= SZ'(bms_pkg::IMG_H_RST);
		end else if (cfg_wr) begin
			unique case (bms_pkg::cfg_idx_t'(cfg_idx))
				bms_pkg::CFG_IMAGE_WIDTH: begin
					img_w_q <= cfg_data;
				end
				bms_pkg::CFG_IMAGE_HEIGHT: begin
					img_h_q <= cfg_data;
				end
				default: begin
					img_w_q <= img_w_q;
				end
			endcase
		end
	end

	bms_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.det_x    (det_x),
		.det_y    (det_y),
		.det_w    (det_w),
		.det_h    (det_h),
		.trk_x    (trk_x),
		.trk_y    (trk_y),
		.trk_w    (trk_w),
		.trk_h    (trk_h),
		.pop      (pop),
		.q_stat   (q_stat),
		.hd_ix    (hd_ix),
		.hd_iy    (hd_iy),
		.hd_dx    (hd_dx),
		.hd_dy    (hd_dy),
		.hd_aw    (hd_aw),
		.hd_ah    (hd_ah),
		.hd_bw    (hd_bw),
		.hd_bh    (hd_bh)
	);

	bms_back #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.pop          (pop),
		.hd_ix        (hd_ix),
		.hd_iy        (hd_iy),
		.hd_dx        (hd_dx),
		.hd_dy        (hd_dy),
		.hd_aw        (hd_aw),
		.hd_ah        (hd_ah),
		.hd_bw        (hd_bw),
		.hd_bh        (hd_bh),
		.image_width  (img_w_q),
		.image_height (img_h_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.score        (score)
	);

	`BMS_ASSERT_SAME(a_score_range, out_valid, score <= SCORE_ONE, "score above one")
	`BMS_ASSERT_SAME(a_stall_not_empty, in_stall, !q_stat.empty, "stall with empty queue")
	`BMS_ASSERT_NEXT(a_empty_no_stall, q_stat.empty, !in_stall, "queue filled in one cycle")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_match_score testbench
// Drives detection/track box pairs through the valid/stall handshake with
// random gaps and back-pressure, predicts each match score from the image
// size settings and checks the scores in order. Several image sizes are
// used, the extremes and the zero diagonal among them.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CB = bms_pkg::COORD_BITS_DEF;
	localparam int FB = bms_pkg::FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic signed [CB-1:0] dx, dy, tx, ty;
		logic        [CB-2:0] dw, dh, tw, th;
	} box_pair_t;

	class score_board;
		logic [FB:0] score_q[$];
		logic [CB-2:0] img_w = (CB-1)'(bms_pkg::IMG_W_RST);
		logic [CB-2:0] img_h = (CB-1)'(bms_pkg::IMG_H_RST);
		int errors = 0;

		static function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned res;
			longint unsigned b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function logic [FB:0] match_score(box_pair_t p);
			longint ax, ay, aw, ah, bx, by, bw, bh;
			longint ix, iy, inter, area_a, area_b, uni, iou, sz, ratio, ddx, ddy, acc;
			longint unsigned ctr_len, diag, r;
			ax = p.dx; ay = p.dy; aw = p.dw; ah = p.dh;
			bx = p.tx; by = p.ty; bw = p.tw; bh = p.th;
			ix = ((ax + aw < bx + bw) ? ax + aw : bx + bw) - ((ax > bx) ? ax : bx);
			iy = ((ay + ah < by + bh) ? ay + ah : by + bh) - ((ay > by) ? ay : by);
			if (ix < 0) ix = 0;
			if (iy < 0) iy = 0;
			inter = ix * iy;
			area_a = aw * ah;
			area_b = bw * bh;
			uni = area_a + area_b - inter;
			iou = (uni > 0) ? (inter << FB) / uni : 0;
			sz = 0;
			if (area_a != 0 && area_b != 0)
				sz = area_a < area_b ? (area_a << FB) / area_b : (area_b << FB) / area_a;
			ddx = (2 * ax + aw) - (2 * bx + bw);
			ddy = (2 * ay + ah) - (2 * by + bh);
			ctr_len = int_sqrt(ddx * ddx + ddy * ddy);
			diag = 2 * int_sqrt(longint'(img_w) * img_w + longint'(img_h) * img_h);
			ratio = 1 << FB;
			if (diag != 0) begin
				r = (ctr_len << FB) / diag;
				if (r < (1 << FB)) ratio = r;
			end
			acc = (1 << (FB - 1)) * iou + ((3 * (1 << FB)) / 10) * ((1 << FB) - ratio)
				+ ((1 << FB) - (1 << (FB - 1)) - (3 * (1 << FB)) / 10) * sz;
			return (FB+1)'(acc >> FB);
		endfunction

		function void note_pair(box_pair_t p);
			score_q.push_back(match_score(p));
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_score(logic [FB:0] got);
			logic [FB:0] want;
			if (score_q.size() == 0) begin
				report($sformatf("unexpected score %0d", got));
			end else begin
				want = score_q.pop_front();
				if (got !== want)
					report($sformatf("score %0d, expected %0d", got, want));
			end
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr = 0;
	logic cfg_idx = 0;
	logic [CB-2:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [CB-1:0] det_x = '0, det_y = '0, trk_x = '0, trk_y = '0;
	logic [CB-2:0] det_w = '0, det_h = '0, trk_w = '0, trk_h = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [FB:0] score;

	score_board sb = new();
	bit quiet = 1;
	int cycles = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	box_match_score u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr(cfg_wr), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.det_x(det_x), .det_y(det_y), .det_w(det_w), .det_h(det_h),
		.trk_x(trk_x), .trk_y(trk_y), .trk_w(trk_w), .trk_h(trk_h),
		.out_valid(out_valid), .out_stall(out_stall), .score(score)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		box_pair_t p;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				p.dx = det_x; p.dy = det_y; p.dw = det_w; p.dh = det_h;
				p.tx = trk_x; p.ty = trk_y; p.tw = trk_w; p.th = trk_h;
				sb.note_pair(p);
			end
			if (out_valid && !out_stall)
				sb.check_score(score);
		end
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = quiet ? 0 : $urandom_range(0, 7);
			if (n > 0) begin
				out_stall = 1;
				repeat (n) @(negedge clk);
				out_stall = 0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	task write_reg(bms_pkg::cfg_idx_t idx, logic [CB-2:0] val);
		cfg_wr = 1;
		cfg_idx = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wr = 0;
		if (idx == bms_pkg::CFG_IMAGE_WIDTH) sb.img_w = val;
		else sb.img_h = val;
	endtask

	task send_pair(box_pair_t p);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		det_x = p.dx; det_y = p.dy; det_w = p.dw; det_h = p.dh;
		trk_x = p.tx; trk_y = p.ty; trk_w = p.tw; trk_h = p.th;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task drain;
		in_valid = 0;
		while (sb.score_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function box_pair_t make_pair(int sx, int sy, int sw, int sh,
			int ux, int uy, int uw, int uh);
		box_pair_t p;
		p.dx = CB'(sx); p.dy = CB'(sy); p.dw = (CB-1)'(sw); p.dh = (CB-1)'(sh);
		p.tx = CB'(ux); p.ty = CB'(uy); p.tw = (CB-1)'(uw); p.th = (CB-1)'(uh);
		return p;
	endfunction

	function box_pair_t random_pair();
		box_pair_t p;
		int k;
		k = $urandom_range(0, 9);
		p.dx = CB'($urandom); p.dy = CB'($urandom);
		p.dw = (CB-1)'($urandom); p.dh = (CB-1)'($urandom);
		p.tx = CB'($urandom); p.ty = CB'($urandom);
		p.tw = (CB-1)'($urandom); p.th = (CB-1)'($urandom);
		if (k < 7) begin
			p.dx = $signed(14'($urandom_range(0, 4000))) - 14'sd500;
			p.dy = $signed(14'($urandom_range(0, 3000))) - 14'sd500;
			p.dw = (CB-1)'($urandom_range(0, 600));
			p.dh = (CB-1)'($urandom_range(0, 600));
			p.tx = p.dx + $signed(14'($urandom_range(0, 400))) - 14'sd200;
			p.ty = p.dy + $signed(14'($urandom_range(0, 400))) - 14'sd200;
			p.tw = (k == 0) ? p.dw : p.dw + (CB-1)'($urandom_range(0, 200));
			p.th = (k == 0) ? p.dh : p.dh + (CB-1)'($urandom_range(0, 200));
		end
		return p;
	endfunction

	initial begin
		int widths[5];
		int heights[5];
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// reset image size in force for the directed pairs
		send_pair(make_pair(0, 0, 100, 100, 0, 0, 100, 100));
		send_pair(make_pair(-8192, -8192, 8191, 8191, 8191, 8191, 8191, 8191));
		send_pair(make_pair(8191, 8191, 8191, 8191, -8192, -8192, 8191, 8191));
		send_pair(make_pair(-8192, -8192, 8191, 8191, -8192, -8192, 8191, 8191));
		send_pair(make_pair(10, 10, 0, 0, 10, 10, 0, 0));
		send_pair(make_pair(10, 10, 0, 50, 10, 10, 40, 50));
		send_pair(make_pair(10, 10, 40, 50, 500, 500, 40, 50));
		send_pair(make_pair(0, 0, 8191, 8191, 0, 0, 1, 1));
		send_pair(make_pair(0, 0, 1, 1, 0, 0, 8191, 8191));
		send_pair(make_pair(0, 0, 10, 10, 5, 5, 10, 10));
		send_pair(make_pair(0, 0, 10, 10, 10, 0, 10, 10));
		send_pair(make_pair(-100, -50, 30, 20, -90, -45, 30, 20));
		send_pair(make_pair(0, 0, 0, 0, 1919, 1079, 1, 1));
		send_pair(make_pair(-8192, 8191, 0, 8191, 8191, -8192, 8191, 0));
		send_pair(make_pair(100, 100, 8191, 1, 100, 100, 1, 8191));
		send_pair(make_pair(-1, -1, 2, 2, 0, 0, 2, 2));
		drain();

		widths = '{1920, 8191, 1, 0, 640};
		heights = '{1080, 8191, 1, 0, 8191};
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) begin
				write_reg(bms_pkg::CFG_IMAGE_WIDTH, (CB-1)'($urandom_range(1, 8191)));
				write_reg(bms_pkg::CFG_IMAGE_HEIGHT, (CB-1)'($urandom_range(1, 8191)));
			end else if (ph > 0) begin
				write_reg(bms_pkg::CFG_IMAGE_WIDTH, (CB-1)'(widths[ph]));
				write_reg(bms_pkg::CFG_IMAGE_HEIGHT, (CB-1)'(heights[ph]));
			end
			for (int i = 0; i < 265; i++) begin
				quiet = (i < 40) || (i >= 200 && i < 230);
				send_pair(random_pair());
			end
			drain();
		end
		quiet = 1;

		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
